// ===== hw/rtl/ttc_pkg.sv =====
package ttc_pkg;

   localparam int COORD_WIDTH      = 16;
   localparam int REVEAL_FRAC_BITS = 16;
   localparam int REVEAL_WIDTH     = REVEAL_FRAC_BITS + 1;
   localparam int THR_WIDTH        = 17;
   localparam int EXT_WIDTH        = (REVEAL_WIDTH > THR_WIDTH) ? REVEAL_WIDTH : THR_WIDTH;
   localparam int QUO_WIDTH        = COORD_WIDTH + 1;
   localparam int PROD_WIDTH       = QUO_WIDTH + EXT_WIDTH;
   localparam int LERP_LATENCY     = QUO_WIDTH + 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [REVEAL_WIDTH-1:0]       reveal_type;
   typedef logic [THR_WIDTH-1:0]          thr_type;
   typedef logic signed [EXT_WIDTH:0]     rdiff_type;

   typedef struct packed {
      coord_type  v0_x;
      coord_type  v0_y;
      reveal_type v0_reveal;
      coord_type  v1_x;
      coord_type  v1_y;
      reveal_type v1_reveal;
      coord_type  v2_x;
      coord_type  v2_y;
      reveal_type v2_reveal;
   } req_type;

   typedef struct packed {
      coord_type p0_x;
      coord_type p0_y;
      coord_type p1_x;
      coord_type p1_y;
      coord_type p2_x;
      coord_type p2_y;
      logic      last;
   } rsp_type;

endpackage

// ===== hw/rtl/triangle_threshold_clipper_top.sv =====
// Clips one triangle per transfer to the region where reveal is at most the
// threshold and returns 0, 1 or 2 triangles. A new triangle can be taken while
// others are in flight, but not in the cycle after a transfer (busy is high).
// Results appear on consecutive cycles after the six interpolation pipelines
// (one restoring-divider stage per quotient bit), the polygon register and the
// output register. The receiver cannot stall; every rsp_valid cycle is a
// transfer. The threshold port is always ready; write it only while idle.
module triangle_threshold_clipper_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ttc_pkg::req_type req_data,
   output logic             rsp_valid,
   output ttc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  ttc_pkg::thr_type csr_data
);

   localparam int LAT = ttc_pkg::LERP_LATENCY;
   localparam int EW  = ttc_pkg::EXT_WIDTH;

   logic busy_ff;
   ttc_pkg::thr_type thr_ff;

   logic             s1_valid_ff;
   ttc_pkg::req_type s1_req_ff;

   ttc_pkg::coord_type vx [0:2];
   ttc_pkg::coord_type vy [0:2];
   ttc_pkg::reveal_type vr [0:2];
   logic [2:0]         vtx_in;
   ttc_pkg::rdiff_type num [0:2];
   ttc_pkg::rdiff_type den [0:2];
   ttc_pkg::coord_type px [0:2];
   ttc_pkg::coord_type py [0:2];

   logic             sd_valid_ff [0:LAT-1];
   logic [2:0]       sd_in_ff    [0:LAT-1];
   ttc_pkg::req_type sd_req_ff   [0:LAT-1];

   ttc_pkg::coord_type ex [0:2];
   ttc_pkg::coord_type ey [0:2];
   ttc_pkg::coord_type cx_in [0:3];
   ttc_pkg::coord_type cy_in [0:3];
   logic [2:0]         cnt_in;
   logic               c_valid_ff;
   logic [2:0]         c_cnt_ff;
   ttc_pkg::coord_type c_x_ff [0:3];
   ttc_pkg::coord_type c_y_ff [0:3];

   logic             rsp_valid_in, rsp_valid_ff;
   ttc_pkg::rsp_type rsp_in, rsp_ff;
   logic             sec_valid_in, sec_valid_ff;
   ttc_pkg::rsp_type sec_in, sec_ff;

   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         thr_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= start && !busy_ff;
         s1_valid_ff <= start && !busy_ff;
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         s1_req_ff <= req_data;
      end
   end

   always_comb begin
      vx[0] = s1_req_ff.v0_x;  vy[0] = s1_req_ff.v0_y;  vr[0] = s1_req_ff.v0_reveal;
      vx[1] = s1_req_ff.v1_x;  vy[1] = s1_req_ff.v1_y;  vr[1] = s1_req_ff.v1_reveal;
      vx[2] = s1_req_ff.v2_x;  vy[2] = s1_req_ff.v2_y;  vr[2] = s1_req_ff.v2_reveal;
   end

   for (genvar i = 0; i < 3; i++) begin : g_edge
      localparam int NX = (i + 1) % 3;
      assign vtx_in[i] = (EW'(vr[i]) <= EW'(thr_ff));
      assign num[i] = {1'b0, EW'(thr_ff)} - {1'b0, EW'(vr[i])};
      assign den[i] = {1'b0, EW'(vr[NX])} - {1'b0, EW'(vr[i])};
      ttc_lerp u_lerp_x (
         .clock (clock),
         .a_x   (vx[i]),
         .b_x   (vx[NX]),
         .num   (num[i]),
         .den   (den[i]),
         .res   (px[i])
      );
      ttc_lerp u_lerp_y (
         .clock (clock),
         .a_x   (vy[i]),
         .b_x   (vy[NX]),
         .num   (num[i]),
         .den   (den[i]),
         .res   (py[i])
      );
   end

   // side line matching the interpolation latency
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            sd_valid_ff[k] <= 1'b0;
         end
      end else begin
         sd_valid_ff[0] <= s1_valid_ff;
         for (int k = 1; k < LAT; k++) begin
            sd_valid_ff[k] <= sd_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      sd_in_ff[0]  <= vtx_in;
      sd_req_ff[0] <= s1_req_ff;
      for (int k = 1; k < LAT; k++) begin
         sd_in_ff[k]  <= sd_in_ff[k-1];
         sd_req_ff[k] <= sd_req_ff[k-1];
      end
   end

   // polygon assembly in edge order
   always_comb begin
      ex[0] = sd_req_ff[LAT-1].v0_x;  ey[0] = sd_req_ff[LAT-1].v0_y;
      ex[1] = sd_req_ff[LAT-1].v1_x;  ey[1] = sd_req_ff[LAT-1].v1_y;
      ex[2] = sd_req_ff[LAT-1].v2_x;  ey[2] = sd_req_ff[LAT-1].v2_y;
      cnt_in = '0;
      for (int k = 0; k < 4; k++) begin
         cx_in[k] = '0;
         cy_in[k] = '0;
      end
      for (int j = 0; j < 3; j++) begin
         if (sd_in_ff[LAT-1][j] && cnt_in < 3'd4) begin
            cx_in[cnt_in[1:0]] = ex[j];
            cy_in[cnt_in[1:0]] = ey[j];
            cnt_in = cnt_in + 3'd1;
         end
         if ((sd_in_ff[LAT-1][j] != sd_in_ff[LAT-1][(j + 1) % 3]) && cnt_in < 3'd4) begin
            cx_in[cnt_in[1:0]] = px[j];
            cy_in[cnt_in[1:0]] = py[j];
            cnt_in = cnt_in + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= sd_valid_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      c_cnt_ff <= cnt_in;
      for (int k = 0; k < 4; k++) begin
         c_x_ff[k] <= cx_in[k];
         c_y_ff[k] <= cy_in[k];
      end
   end

   // fan from the first point, second triangle in the following cycle
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_in       = sec_ff;
      sec_valid_in = 1'b0;
      sec_in       = sec_ff;
      if (c_valid_ff && c_cnt_ff >= 3'd3) begin
         rsp_valid_in = 1'b1;
         rsp_in.p0_x  = c_x_ff[0];  rsp_in.p0_y = c_y_ff[0];
         rsp_in.p1_x  = c_x_ff[1];  rsp_in.p1_y = c_y_ff[1];
         rsp_in.p2_x  = c_x_ff[2];  rsp_in.p2_y = c_y_ff[2];
         rsp_in.last  = (c_cnt_ff == 3'd3);
         sec_valid_in = (c_cnt_ff == 3'd4);
         sec_in.p0_x  = c_x_ff[0];  sec_in.p0_y = c_y_ff[0];
         sec_in.p1_x  = c_x_ff[2];  sec_in.p1_y = c_y_ff[2];
         sec_in.p2_x  = c_x_ff[3];  sec_in.p2_y = c_y_ff[3];
         sec_in.last  = 1'b1;
      end else if (sec_valid_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      sec_ff <= sec_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_transfer : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after transfer");

   a_second_follows : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |=> (rsp_valid && rsp_data.last))
      else $error("second triangle missing");

   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> !sec_valid_ff)
      else $error("polygon collides with pending triangle");
`endif

endmodule

// ===== hw/rtl/ttc_lerp.sv =====
module ttc_lerp (
   input  logic                clock,
   input  ttc_pkg::coord_type  a_x,
   input  ttc_pkg::coord_type  b_x,
   input  ttc_pkg::rdiff_type  num,
   input  ttc_pkg::rdiff_type  den,
   output ttc_pkg::coord_type  res
);

   localparam int CW = ttc_pkg::COORD_WIDTH;
   localparam int QW = ttc_pkg::QUO_WIDTH;
   localparam int EW = ttc_pkg::EXT_WIDTH;
   localparam int PW = ttc_pkg::PROD_WIDTH;

   logic signed [QW-1:0] diff;
   logic signed [QW-1:0] diff_neg;
   logic signed [EW:0]   num_neg;
   logic signed [EW:0]   den_neg;

   logic [QW-1:0]      dmag_ff;
   logic [EW-1:0]      nmag_ff;
   logic [EW-1:0]      dvmag_ff;
   logic               neg_ff;
   ttc_pkg::coord_type a_ff;

   logic [PW-1:0]      rem_ff [0:QW];
   logic [QW-1:0]      q_ff   [0:QW];
   logic [EW-1:0]      dv_ff  [0:QW];
   logic               sg_ff  [0:QW];
   ttc_pkg::coord_type ax_ff  [0:QW];

   logic signed [QW-1:0] q_signed;
   logic signed [QW-1:0] sum;
   ttc_pkg::coord_type   res_ff;

   assign diff     = {b_x[CW-1], b_x} - {a_x[CW-1], a_x};
   assign diff_neg = -diff;
   assign num_neg  = -num;
   assign den_neg  = -den;

   // magnitudes and result sign
   always_ff @(posedge clock) begin
      dmag_ff  <= diff[QW-1] ? diff_neg : diff;
      nmag_ff  <= num[EW] ? num_neg[EW-1:0] : num[EW-1:0];
      dvmag_ff <= den[EW] ? den_neg[EW-1:0] : den[EW-1:0];
      neg_ff   <= diff[QW-1] ^ num[EW] ^ den[EW];
      a_ff     <= a_x;
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= dmag_ff * nmag_ff;
      q_ff[0]   <= '0;
      dv_ff[0]  <= dvmag_ff;
      sg_ff[0]  <= neg_ff;
      ax_ff[0]  <= a_ff;
   end

   // one quotient bit per stage, msb first
   for (genvar k = 0; k < QW; k++) begin : g_div
      localparam int SH = QW - 1 - k;
      logic [PW-1:0] trial;
      logic          ge;
      assign trial = {{QW{1'b0}}, dv_ff[k]} << SH;
      assign ge    = rem_ff[k] >= trial;
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge ? rem_ff[k] - trial : rem_ff[k];
         q_ff[k+1]   <= q_ff[k] | (ge ? (QW'(1) << SH) : '0);
         dv_ff[k+1]  <= dv_ff[k];
         sg_ff[k+1]  <= sg_ff[k];
         ax_ff[k+1]  <= ax_ff[k];
      end
   end

   assign q_signed = sg_ff[QW] ? -q_ff[QW] : q_ff[QW];
   assign sum      = {ax_ff[QW][CW-1], ax_ff[QW]} + q_signed;

   always_ff @(posedge clock) begin
      res_ff <= sum[CW-1:0];
   end

   assign res = res_ff;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum int {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   ttc_pkg::req_type req_data;
   logic             rsp_valid;
   ttc_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   ttc_pkg::thr_type csr_data;

   ttc_pkg::req_type tri_queue[$];
   ttc_pkg::rsp_type clip_queue[$];
   ttc_pkg::thr_type threshold;
   idle_mode_type    idle_mode;
   int               mismatch_count = 0;
   int               cycle_count = 0;
   bit               driving;

   triangle_threshold_clipper_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_triangle(input ttc_pkg::req_type t);
      tri_queue = {tri_queue, t};
   endtask

   function automatic ttc_pkg::coord_type lerp_coord(input ttc_pkg::coord_type a,
                                                     input ttc_pkg::coord_type b,
                                                     input longint num, input longint den);
      longint prod;
      prod = (longint'(b) - longint'(a)) * num;
      return ttc_pkg::coord_type'(longint'(a) + prod / den);
   endfunction

   task automatic predict_clip(input ttc_pkg::req_type t);
      ttc_pkg::coord_type vx[3];
      ttc_pkg::coord_type vy[3];
      longint             vr[3];
      ttc_pkg::coord_type px[4];
      ttc_pkg::coord_type py[4];
      int                 count;
      int                 j;
      bit                 ina;
      bit                 inb;
      ttc_pkg::rsp_type   r;
      vx[0] = t.v0_x; vy[0] = t.v0_y; vr[0] = longint'(t.v0_reveal);
      vx[1] = t.v1_x; vy[1] = t.v1_y; vr[1] = longint'(t.v1_reveal);
      vx[2] = t.v2_x; vy[2] = t.v2_y; vr[2] = longint'(t.v2_reveal);
      count = 0;
      for (int i = 0; i < 3; i++) begin
         j = (i + 1) % 3;
         ina = vr[i] <= longint'(threshold);
         inb = vr[j] <= longint'(threshold);
         if (ina && count < 4) begin
            px[count] = vx[i];
            py[count] = vy[i];
            count++;
         end
         if (ina != inb && count < 4) begin
            px[count] = lerp_coord(vx[i], vx[j], longint'(threshold) - vr[i], vr[j] - vr[i]);
            py[count] = lerp_coord(vy[i], vy[j], longint'(threshold) - vr[i], vr[j] - vr[i]);
            count++;
         end
      end
      if (count >= 3) begin
         r.p0_x = px[0]; r.p0_y = py[0];
         r.p1_x = px[1]; r.p1_y = py[1];
         r.p2_x = px[2]; r.p2_y = py[2];
         r.last = (count == 3);
         clip_queue = {clip_queue, r};
         if (count == 4) begin
            r.p1_x = px[2]; r.p1_y = py[2];
            r.p2_x = px[3]; r.p2_y = py[3];
            r.last = 1'b1;
            clip_queue = {clip_queue, r};
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else if (start && !busy) begin
         predict_clip(req_data);
         void'(tri_queue.pop_front());
         if (tri_queue.size() > 0 && driving &&
             !((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) && $urandom_range(99) < 47)) begin
            req_data <= tri_queue[0];
         end else begin
            start <= 1'b0;
         end
      end else if (!start && tri_queue.size() > 0 && driving) begin
         if (!((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) && $urandom_range(99) < 47)) begin
            start    <= 1'b1;
            req_data <= tri_queue[0];
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      ttc_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (clip_queue.size() == 0) begin
            report_mismatch("unexpected triangle transfer", 1, 0);
         end else begin
            want = clip_queue.pop_front();
            if (rsp_data.p0_x !== want.p0_x) report_mismatch("p0_x", rsp_data.p0_x, want.p0_x);
            if (rsp_data.p0_y !== want.p0_y) report_mismatch("p0_y", rsp_data.p0_y, want.p0_y);
            if (rsp_data.p1_x !== want.p1_x) report_mismatch("p1_x", rsp_data.p1_x, want.p1_x);
            if (rsp_data.p1_y !== want.p1_y) report_mismatch("p1_y", rsp_data.p1_y, want.p1_y);
            if (rsp_data.p2_x !== want.p2_x) report_mismatch("p2_x", rsp_data.p2_x, want.p2_x);
            if (rsp_data.p2_y !== want.p2_y) report_mismatch("p2_y", rsp_data.p2_y, want.p2_y);
            if (rsp_data.last !== want.last) report_mismatch("last", rsp_data.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic write_threshold(input ttc_pkg::thr_type value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      threshold = value;
   endtask

   task automatic wait_drained();
      driving = 1'b1;
      while (tri_queue.size() > 0 || start) @(posedge clock);
      driving = 1'b0;
      while (clip_queue.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic ttc_pkg::reveal_type rand_reveal(input ttc_pkg::thr_type thr);
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel == 0) return ttc_pkg::reveal_type'($urandom);
      if (sel == 1) return ttc_pkg::reveal_type'(thr);
      if (sel < 5) return ttc_pkg::reveal_type'($urandom_range(65536));
      return ttc_pkg::reveal_type'(longint'(thr) + $urandom_range(4096) - 2048);
   endfunction

   function automatic ttc_pkg::req_type rand_triangle(input ttc_pkg::thr_type thr);
      ttc_pkg::req_type t;
      logic [159:0]     raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      t = raw[$bits(ttc_pkg::req_type)-1:0];
      if ($urandom_range(3) != 0) begin
         t.v0_x = ttc_pkg::coord_type'($urandom_range(4095) - 2048);
         t.v1_x = ttc_pkg::coord_type'($urandom_range(4095) - 2048);
      end
      t.v0_reveal = rand_reveal(thr);
      t.v1_reveal = rand_reveal(thr);
      t.v2_reveal = rand_reveal(thr);
      return t;
   endfunction

   function automatic ttc_pkg::req_type make_triangle(input ttc_pkg::coord_type c,
                                                      input ttc_pkg::reveal_type r0,
                                                      input ttc_pkg::reveal_type r1,
                                                      input ttc_pkg::reveal_type r2);
      ttc_pkg::req_type t;
      t.v0_x = c;  t.v0_y = -c; t.v0_reveal = r0;
      t.v1_x = -c; t.v1_y = c;  t.v1_reveal = r1;
      t.v2_x = c;  t.v2_y = c;  t.v2_reveal = r2;
      return t;
   endfunction

   initial begin
      ttc_pkg::thr_type thr_list[6];
      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_data       = '0;
      threshold      = '0;
      driving        = 1'b0;
      idle_mode      = IDLE_NONE;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, all inside, all outside, one and two vertices inside
      write_threshold(ttc_pkg::thr_type'(32768));
      queue_triangle(make_triangle(16'sh7fff, 17'd0, 17'd0, 17'd0));
      queue_triangle(make_triangle(-16'sh8000, 17'd0, 17'd100, 17'd65536));
      queue_triangle(make_triangle(16'sh7fff, 17'd65536, 17'd65536, 17'd0));
      queue_triangle(make_triangle(-16'sh8000, 17'd1, 17'd65536, 17'd32768));
      queue_triangle(make_triangle(16'sh1234, 17'd70000, 17'd32768, 17'd131071));
      queue_triangle(make_triangle(-16'sh8000, 17'd131071, 17'd131071, 17'd131071));
      queue_triangle(make_triangle(16'sh7fff, 17'd32769, 17'd32767, 17'd32769));
      queue_triangle(make_triangle(16'sh0400, 17'd40000, 17'd0, 17'd0));
      queue_triangle(ttc_pkg::req_type'('1));
      queue_triangle(ttc_pkg::req_type'('0));
      wait_drained();
      write_threshold(ttc_pkg::thr_type'(0));
      queue_triangle(make_triangle(16'sh7fff, 17'd0, 17'd65536, 17'd1));
      queue_triangle(make_triangle(-16'sh8000, 17'd1, 17'd1, 17'd0));
      wait_drained();
      write_threshold(ttc_pkg::thr_type'(131071));
      queue_triangle(make_triangle(16'sh7fff, 17'd131071, 17'd65536, 17'd0));
      queue_triangle(ttc_pkg::req_type'('1));
      wait_drained();

      thr_list = '{ttc_pkg::thr_type'(65536), ttc_pkg::thr_type'(0),
                   ttc_pkg::thr_type'(131071), ttc_pkg::thr_type'(32768),
                   ttc_pkg::thr_type'($urandom), ttc_pkg::thr_type'(1)};
      for (int p = 0; p < 8; p++) begin
         idle_mode = idle_mode_type'(p % 4);
         write_threshold(thr_list[p % 6]);
         for (int n = 0; n < 50; n++) queue_triangle(rand_triangle(threshold));
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
hw/rtl/ttc_pkg.sv
hw/rtl/ttc_lerp.sv
hw/rtl/triangle_threshold_clipper_top.sv
verif/tb_top.sv
